@@ hdl/raster_median_filter_assert.svh @@
// Assertion helpers for the raster median filter.
`ifndef RASTER_MEDIAN_FILTER_ASSERT_SVH
`define RASTER_MEDIAN_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define RMF_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define RMF_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ hdl/rmf_pkg.sv @@
package rmf_pkg;

    localparam int PIXEL_BITS_DEF = 8;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Window half size is fixed at one: 3x3 window, median is element 4 of 9.
    localparam int WIN_SIDE = 3;
    localparam int WIN_TAPS = WIN_SIDE * WIN_SIDE;
    localparam int MED_IDX  = WIN_TAPS / 2;

    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 2;
    localparam int MIN_SIZE     = WIN_SIDE;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

endpackage

@@ hdl/rmf_ram.sv @@
module rmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rmf_median9.sv @@
module rmf_median9 #(
    parameter int W = 8
) (
    input  logic [rmf_pkg::WIN_TAPS-1:0][W-1:0] i_taps,
    output logic [W-1:0]                        o_median
);
    import rmf_pkg::*;

    // Compare-exchange network that leaves the median of nine in slot four.
    localparam int NPAIR = 19;
    localparam int PA [NPAIR] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
    localparam int PB [NPAIR] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

    logic [W-1:0] v [WIN_TAPS];

    always_comb begin
        logic [W-1:0] t;
        t = '0;
        for (int k = 0; k < WIN_TAPS; k++) begin
            v[k] = i_taps[k];
        end
        for (int k = 0; k < NPAIR; k++) begin
            if (v[PA[k]] > v[PB[k]]) begin
                t        = v[PA[k]];
                v[PA[k]] = v[PB[k]];
                v[PB[k]] = t;
            end
        end
        o_median = v[MED_IDX];
    end

endmodule

@@ hdl/raster_median_filter.sv @@
// 3x3 median filter on a raster pixel stream. One item (pixel or flush tick)
// is taken per clock cycle unless stalled, with the result valid next cycle;
// the single output register stalls input only when full and stalled. Two
// line buffers (one RAM each, indexed by column) feed a 3x3 window register,
// and a history ring RAM supplies the centre pixel for border positions, so
// results trail input by one row plus one pixel. After the last pixel of a
// frame, flush ticks drain the remaining row plus one results; pixels of the
// next frame drain them too. A radius, width or height write restarts the
// stream. Radius writes are accepted but the window half size is always one.
`include "raster_median_filter_assert.svh"

module raster_median_filter #(
    parameter int PIXEL_BITS = rmf_pkg::PIXEL_BITS_DEF,
    parameter int MAX_WIDTH  = rmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rmf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rmf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [rmf_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [PIXEL_BITS-1:0]         i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [PIXEL_BITS-1:0]         o_pixel_out,
    output logic                          o_frame_end
);
    import rmf_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int RB = $clog2(MAX_HEIGHT);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int AB = $clog2(MAX_WIDTH + 3);
    localparam int RING_DEPTH = 1 << AB;
    localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    logic [WB-1:0] r_w;
    logic [HB-1:0] r_h;
    logic [CB-1:0] r_in_col, n_in_col;
    logic [CB-1:0] r_out_col, n_out_col;
    logic [RB-1:0] r_out_row, n_out_row;
    logic [AB-1:0] r_pending, n_pending;
    logic [AB-1:0] r_wr, n_wr;
    logic          r_byp;
    logic [PIXEL_BITS-1:0] r_byp_pix;
    logic          r_out_valid;
    logic [PIXEL_BITS-1:0] r_pixel_out;
    logic          r_frame_end;

    logic [WIN_SIDE-1:0][WIN_SIDE-1:0][PIXEL_BITS-1:0] r_win, n_win;
    logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] taps;
    logic [PIXEL_BITS-1:0] median, center, lb0_rd, lb1_rd, ring_rd;

    logic acc, pix_acc, restart, emit;
    logic col_last, row_last, row_pen, in_col_last, border;
    logic [AB-1:0] p1, need, n_c;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign acc        = i_in_valid && !o_in_stall;
    assign pix_acc    = acc && !i_operation;
    assign restart    = i_cfg_we && (i_cfg_index == CFG_RADIUS || i_cfg_index == CFG_WIDTH
                                     || i_cfg_index == CFG_HEIGHT);

    assign col_last    = (WB'(r_out_col) == r_w - 1'b1);
    assign row_last    = (HB'(r_out_row) == r_h - 1'b1);
    assign row_pen     = (HB'(r_out_row) == r_h - 2'd2);
    assign in_col_last = (WB'(r_in_col) == r_w - 1'b1);
    assign border      = (r_out_col == '0) || col_last || (r_out_row == '0) || row_last;

    // Pixels still to come after the output position before it can be given.
    always_comb begin
        if (row_last) begin
            need = AB'(r_w - 1'b1 - WB'(r_out_col));
        end else if (row_pen && col_last) begin
            need = AB'(r_w);
        end else begin
            need = AB'(r_w) + 1'b1;
        end
    end

    assign p1   = pix_acc ? r_pending + 1'b1 : r_pending;
    assign emit = acc && (p1 > need);

    always_comb begin
        n_win = r_win;
        if (pix_acc) begin
            for (int r = 0; r < WIN_SIDE; r++) begin
                for (int c = 0; c < WIN_SIDE - 1; c++) begin
                    n_win[r][c] = r_win[r][c+1];
                end
            end
            n_win[0][WIN_SIDE-1] = lb1_rd;
            n_win[1][WIN_SIDE-1] = lb0_rd;
            n_win[2][WIN_SIDE-1] = i_pixel_in;
        end
        for (int r = 0; r < WIN_SIDE; r++) begin
            for (int c = 0; c < WIN_SIDE; c++) begin
                taps[r*WIN_SIDE + c] = n_win[r][c];
            end
        end
    end

    always_comb begin
        n_pending = r_pending;
        n_wr      = r_wr;
        n_in_col  = r_in_col;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (pix_acc) begin
            n_wr     = r_wr + 1'b1;
            n_in_col = in_col_last ? '0 : r_in_col + 1'b1;
        end
        if (acc) begin
            n_pending = p1 - AB'(emit);
        end
        if (emit) begin
            n_out_col = col_last ? '0 : r_out_col + 1'b1;
            if (col_last) begin
                n_out_row = row_last ? '0 : r_out_row + 1'b1;
            end
        end
        if (restart) begin
            n_pending = '0;
            n_in_col  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    // Centre pixel: the item just taken, a pixel written last edge, or the ring.
    assign n_c = n_wr - n_pending;
    always_comb begin
        if (r_pending == '0) begin
            center = i_pixel_in;
        end else if (r_byp) begin
            center = r_byp_pix;
        end else begin
            center = ring_rd;
        end
    end

    rmf_median9 #(.W(PIXEL_BITS)) u_median (
        .i_taps   (taps),
        .o_median (median)
    );

    rmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_lb0 (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr (r_in_col),
        .i_wdata (i_pixel_in),
        .i_raddr (n_in_col),
        .o_rdata (lb0_rd)
    );

    rmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_lb1 (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr (r_in_col),
        .i_wdata (lb0_rd),
        .i_raddr (n_in_col),
        .o_rdata (lb1_rd)
    );

    rmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr (r_wr),
        .i_wdata (i_pixel_in),
        .i_raddr (n_c),
        .o_rdata (ring_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w         <= WB'(W_RST);
            r_h         <= HB'(H_RST);
            r_in_col    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_pending   <= '0;
            r_wr        <= '0;
            r_byp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_WIDTH) begin
                if (i_cfg_data < CFG_BITS'(MIN_SIZE)) begin
                    r_w <= WB'(MIN_SIZE);
                end else if (int'(i_cfg_data) > MAX_WIDTH) begin
                    r_w <= WB'(MAX_WIDTH);
                end else begin
                    r_w <= WB'(i_cfg_data);
                end
            end
            if (i_cfg_we && i_cfg_index == CFG_HEIGHT) begin
                if (i_cfg_data < CFG_BITS'(MIN_SIZE)) begin
                    r_h <= HB'(MIN_SIZE);
                end else if (int'(i_cfg_data) > MAX_HEIGHT) begin
                    r_h <= HB'(MAX_HEIGHT);
                end else begin
                    r_h <= HB'(i_cfg_data);
                end
            end
            r_in_col  <= n_in_col;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pending <= n_pending;
            r_wr      <= n_wr;
            // Ring read of the address being written this edge sees old data.
            r_byp     <= pix_acc && (n_c == r_wr);
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win     <= n_win;
        r_byp_pix <= i_pixel_in;
        if (emit) begin
            r_pixel_out <= border ? center : median;
            r_frame_end <= row_last && col_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign o_frame_end = r_frame_end;

    `RMF_ASSERT_NOW(a_pending_bound, 1'b1, (WB+1)'(r_pending) <= (WB+1)'(r_w) + 2'd2, "pending exceeds lag")
    `RMF_ASSERT_NOW(a_bypass_one, r_byp, r_pending == AB'(1), "bypass without single pending item")
    `RMF_ASSERT_NEXT(a_frame_wrap, emit && row_last && col_last, r_out_row == '0 && r_out_col == '0, "output position did not wrap")

endmodule

@@ sim/rmf_checker.sv @@
module rmf_checker #(
    parameter logic OP_FLUSH = 1'b1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rmf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [rmf_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_operation,
    input  logic [7:0]                       i_pixel_in,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [7:0]                       i_pixel_out,
    input  logic                             i_frame_end,
    output int                               o_fail_cnt,
    output int                               o_held,
    output int                               o_waiting,
    output int                               o_results
);
    import rmf_pkg::*;

    localparam int HIST_LEN = 2 * (MAX_WIDTH_DEF + 1) + 1;

    typedef struct packed {
        logic [7:0] pix;
        logic       fend;
    } t_filtered;

    logic [7:0] history [HIST_LEN];
    t_filtered  filtered_q[$];
    int         wr_pos, held, in_r, in_c, out_r, out_c;
    int         reg_radius, reg_width, reg_height;
    int         fails, results;

    task automatic step_pos(inout int row, inout int col, input int w, input int h);
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
    endtask

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    task automatic predict_item(input logic op, input logic [7:0] px);
        int        rad, w, h, lag, total, lin, need, ctr, n, k;
        logic [7:0] win [WIN_TAPS];
        logic [7:0] v;
        bit        border;
        t_filtered res;
        rad   = clip(reg_radius, 1, 1);
        w     = clip(reg_width, 2 * rad + 1, MAX_WIDTH_DEF);
        h     = clip(reg_height, 2 * rad + 1, MAX_HEIGHT_DEF);
        lag   = rad * w + rad;
        total = w * h;
        if (op != OP_FLUSH) begin
            history[wr_pos] = px;
            wr_pos = (wr_pos + 1) % HIST_LEN;
            if (held < HIST_LEN) held++;
            step_pos(in_r, in_c, w, h);
        end
        lin  = out_r * w + out_c;
        need = total - 1 - lin;
        if (need > lag) need = lag;
        if (held < need + 1) return;
        ctr    = (wr_pos + HIST_LEN - held) % HIST_LEN;
        border = out_c < rad || out_c >= w - rad || out_r < rad || out_r >= h - rad;
        if (border) begin
            res.pix = history[ctr];
        end else begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++)
                    win[n++] = history[(ctr + HIST_LEN + dy * w + dx) % HIST_LEN];
            // insertion sort, take the middle
            for (int i = 1; i < WIN_TAPS; i++) begin
                v = win[i];
                k = i;
                while (k > 0 && win[k-1] > v) begin
                    win[k] = win[k-1];
                    k--;
                end
                win[k] = v;
            end
            res.pix = win[MED_IDX];
        end
        res.fend = (lin == total - 1);
        filtered_q.push_back(res);
        held--;
        step_pos(out_r, out_c, w, h);
    endtask

    always @(posedge i_clk) begin : monitor
        t_filtered want;
        if (!i_rst_n) begin
            foreach (history[i]) history[i] = '0;
            filtered_q.delete();
            wr_pos = 0; held = 0;
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
            reg_radius = 1; reg_width = MAX_WIDTH_DEF; reg_height = MAX_HEIGHT_DEF;
            fails = 0; results = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (filtered_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: unexpected result pixel=%0d frame_end=%0b",
                                 i_pixel_out, i_frame_end);
                end else begin
                    want = filtered_q.pop_front();
                    if (want.pix !== i_pixel_out || want.fend !== i_frame_end) begin
                        fails++;
                        if (fails <= 10)
                            $display("ERROR: result %0d: pixel exp %0d got %0d, %s%0b got %0b",
                                     results, want.pix, i_pixel_out, "frame_end exp ",
                                     want.fend, i_frame_end);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RADIUS: reg_radius = i_cfg_data[0];
                    CFG_WIDTH:  reg_width  = i_cfg_data;
                    CFG_HEIGHT: reg_height = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index inside {CFG_RADIUS, CFG_WIDTH, CFG_HEIGHT}) begin
                    // restart the stream, drop anything held
                    in_r = 0; in_c = 0; out_r = 0; out_c = 0; held = 0;
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_item(i_operation, i_pixel_in);
        end
        o_held     <= held;
        o_waiting  <= filtered_q.size();
        o_fail_cnt <= fails;
        o_results  <= results;
    end
endmodule

@@ sim/tb.sv @@
module tb;
    import rmf_pkg::*;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic                    i_clk, i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]     i_cfg_data;
    logic                    i_in_valid, o_in_stall, i_operation;
    logic [7:0]              i_pixel_in;
    logic                    o_out_valid, i_out_stall, o_frame_end;
    logic [7:0]              o_pixel_out;

    int  fail_cnt, held, waiting, results;
    int  frame_w, frame_h, cycles, leftover;
    int  pixels_sent, flushes_sent, frames_sent, phases;
    bit  no_gaps, hold_go, hold_done;

    raster_median_filter DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_stall, .i_operation, .i_pixel_in,
        .o_out_valid, .i_out_stall, .o_pixel_out, .o_frame_end
    );

    rmf_checker #(.OP_FLUSH(OP_FLUSH)) u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_operation, .i_pixel_in,
        .i_out_valid(o_out_valid), .i_out_stall, .i_pixel_out(o_pixel_out),
        .i_frame_end(o_frame_end),
        .o_fail_cnt(fail_cnt), .o_held(held), .o_waiting(waiting), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // output side back-pressure, with one long hold-off on request
    initial begin
        i_out_stall = 0;
        hold_done   = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1;
                i_out_stall <= 1;
                repeat (700) @(posedge i_clk);
            end
            i_out_stall <= 0;
            repeat (($urandom % 10 == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12))
                @(posedge i_clk);
            i_out_stall <= 1;
            repeat (($urandom % 10 == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3))
                @(posedge i_clk);
        end
    end

    function automatic logic [7:0] pick_pixel();
        case ($urandom % 8)
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send(input logic op, input logic [7:0] px);
        int gap;
        gap = 0;
        if (!no_gaps)
            case ($urandom % 10)
                0, 1, 2: gap = $urandom_range(1, 3);
                3:       gap = ($urandom % 4 == 0) ? $urandom_range(20, 60) : 0;
                default: gap = 0;
            endcase
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_operation <= op;
        i_pixel_in  <= px;
        do @(posedge i_clk); while (o_in_stall);
        if (op == OP_FLUSH) flushes_sent++;
        else pixels_sent++;
    endtask

    task automatic settle();
        int guard;
        i_in_valid <= 0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while ((waiting != 0 || held != 0) && guard < 20000);
        // a flush accepted past the last result may still be in flight
        repeat (8) @(posedge i_clk);
    endtask

    task automatic drain();
        while (held != 0) send(OP_FLUSH, 8'($urandom));
        settle();
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_BITS'(val);
        @(posedge i_clk);
        i_cfg_we    <= 0;
        case (idx)
            CFG_WIDTH:  frame_w = (val < MIN_SIZE) ? MIN_SIZE : (val > 1024) ? 1024 : val;
            CFG_HEIGHT: frame_h = (val < MIN_SIZE) ? MIN_SIZE : (val > 1024) ? 1024 : val;
            default: ;
        endcase
    endtask

    task automatic setup(input int w, input int h);
        cfg_write(CFG_RADIUS, int'($urandom_range(0, 2047)));
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
        phases++;
    endtask

    task automatic frames(input int n, input bit noisy);
        for (int f = 0; f < n; f++) begin
            for (int p = 0; p < frame_w * frame_h; p++) begin
                // stray flush ticks mid-frame have nothing to drain
                if (noisy && $urandom % 30 == 0) send(OP_FLUSH, pick_pixel());
                send(OP_PIXEL, pick_pixel());
            end
            frames_sent++;
        end
        drain();
    endtask

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = CFG_RADIUS; i_cfg_data = '0;
        i_in_valid = 0; i_operation = OP_PIXEL; i_pixel_in = '0;
        no_gaps = 0; hold_go = 0; leftover = 0;
        pixels_sent = 0; flushes_sent = 0; frames_sent = 0; phases = 0;
        frame_w = 1024; frame_h = 1024;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // flush with nothing ready, then smallest frame with out-of-range sizes
        send(OP_FLUSH, 8'hFF);
        send(OP_FLUSH, 8'h00);
        settle();
        cfg_write(CFG_RADIUS, 0);
        cfg_write(CFG_WIDTH, 0);
        cfg_write(CFG_HEIGHT, 1);
        cfg_write(CFG_SPARE, 11'h7FF);
        send(OP_PIXEL, 8'hFF); send(OP_PIXEL, 8'h00); send(OP_PIXEL, 8'h80);
        send(OP_PIXEL, 8'h01); send(OP_PIXEL, 8'hFE); send(OP_PIXEL, 8'h7F);
        send(OP_PIXEL, 8'hAA); send(OP_PIXEL, 8'h55); send(OP_PIXEL, 8'hFF);
        frames_sent++;
        drain();
        cfg_write(CFG_RADIUS, 1);
        cfg_write(CFG_WIDTH, 2);
        cfg_write(CFG_HEIGHT, 2);
        for (int i = 0; i < 9; i++) send(OP_PIXEL, (i % 2) ? 8'hFF : 8'h00);
        frames_sent++;
        drain();

        // long output hold-off while input keeps coming
        setup(40, 4);
        hold_go = 1;
        wait (hold_done);
        frames(1, 0);
        setup(3, 60);
        no_gaps = 1;
        frames(1, 0);
        no_gaps = 0;
        setup(120, 3);
        frames(1, 1);
        while (pixels_sent < 1900) begin
            setup($urandom_range(3, 12), $urandom_range(3, 9));
            no_gaps = ($urandom % 4 == 0);
            if ($urandom % 5 == 0) cfg_write(CFG_SPARE, $urandom_range(0, 2047));
            frames($urandom_range(1, 3), 1);
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (waiting != 0) leftover = 1;
        $display("Covered %0d frames over %0d configurations: %0d pixels, %0d flush ticks.",
                 frames_sent, phases, pixels_sent, flushes_sent);
        $display("Checked %0d filtered pixels, %0d mismatches.", results, fail_cnt);
        if (fail_cnt == 0 && leftover == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
